@@ design/lpy_pkg.sv @@
`default_nettype none
package lpy_pkg;

	localparam int DataW    = 12;
	localparam int ApbDataW = 32;
	localparam int ApbAddrW = 3;
	localparam int CalcW    = 16;

	localparam logic [DataW-1:0] Full = DataW'(4095);

	typedef enum logic [0:0] {
		REG_TARGET_LABEL = 1'b0
	} reg_index_t;

	typedef logic [DataW-1:0] chan_t;

endpackage
`default_nettype wire

@@ design/lpy_if.sv @@
`default_nettype none
interface lpy_vox_if;
	logic                      valid;
	logic                      ready;
	logic [lpy_pkg::DataW-1:0] intensity;
	logic [lpy_pkg::DataW-1:0] voxel_label;

	modport source (output valid, output intensity, output voxel_label, input ready);
	modport sink   (input valid, input intensity, input voxel_label, output ready);
endinterface

interface lpy_pix_if;
	logic                      valid;
	logic                      ready;
	logic [lpy_pkg::DataW-1:0] red;
	logic [lpy_pkg::DataW-1:0] green;
	logic [lpy_pkg::DataW-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

@@ design/lpy_apb_regs.sv @@
`default_nettype none
module lpy_apb_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lpy_pkg::ApbAddrW-1:0] paddr,
	input  wire logic [lpy_pkg::ApbDataW-1:0] pwdata,
	output logic      [lpy_pkg::ApbDataW-1:0] prdata,
	output logic                              pready,
	output lpy_pkg::chan_t                    target_label
);
	import lpy_pkg::*;

	logic       hit;
	chan_t      target_label_q;

	// Register i sits at byte address 4*i; only the low word offset is decoded.
	assign hit    = (paddr[ApbAddrW-1:2] == 1'(REG_TARGET_LABEL));
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_label_q <= '0;
		end else if (psel && penable && pwrite && pready && hit) begin
			target_label_q <= pwdata[DataW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(ApbDataW-DataW){1'b0}}, target_label_q};
		end
	end

	assign target_label = target_label_q;
endmodule
`default_nettype wire

@@ design/lpy_color.sv @@
`default_nettype none
module lpy_color (
	input  wire lpy_pkg::chan_t intensity,
	input  wire lpy_pkg::chan_t voxel_label,
	input  wire lpy_pkg::chan_t target_label,
	output lpy_pkg::chan_t      red,
	output lpy_pkg::chan_t      green,
	output lpy_pkg::chan_t      blue
);
	import lpy_pkg::*;

	function automatic chan_t clamp12(input logic signed [CalcW-1:0] v);
		chan_t res;
		if (v < 0) begin
			res = '0;
		end else if (v > $signed({{(CalcW-DataW){1'b0}}, Full})) begin
			res = Full;
		end else begin
			res = v[DataW-1:0];
		end
		return res;
	endfunction

	logic signed [CalcW-1:0] y, quad, g_lo, g_min;
	logic signed [CalcW-1:0] hr, hg, hb, cg, co;
	chan_t                   r_c, g_c, b_c;

	always_comb begin
		y     = $signed({{(CalcW-DataW){1'b0}}, intensity});
		quad  = y <<< 2;
		r_c   = clamp12(quad - CalcW'(8190));
		b_c   = clamp12(CalcW'(8190) - quad);
		g_lo  = CalcW'(16380) - quad;
		g_min = (quad < g_lo) ? quad : g_lo;
		g_c   = clamp12(g_min);
		hr    = $signed({{(CalcW-DataW){1'b0}}, r_c});
		hg    = $signed({{(CalcW-DataW){1'b0}}, g_c});
		hb    = $signed({{(CalcW-DataW){1'b0}}, b_c});
		// Both numerators stay non-negative over the hue range, so shifts floor exactly.
		cg    = ((hg <<< 1) - hr - hb + CalcW'(8190)) >>> 2;
		co    = (hr - hb + CalcW'(4095)) >>> 1;
		if (voxel_label != target_label) begin
			red   = intensity;
			green = intensity;
			blue  = intensity;
		end else begin
			red   = clamp12(y - cg + co);
			green = clamp12(y + cg - CalcW'(2048));
			blue  = clamp12(y - cg - co + CalcW'(4095));
		end
	end
endmodule
`default_nettype wire

@@ design/label_pseudocolor_ycgco_top.sv @@
// Label pseudo-colouring block with YCgCo luma replacement.
// Voxel words (intensity, voxel_label) enter on the voxel channel and RGB
// words (red, green, blue) leave on the pixel channel; both use valid/ready.
// Voxels whose label equals target_label are mapped through a jet-style hue,
// converted to YCgCo, given the intensity as luma and converted back to RGB,
// each channel saturated to 12 bits. Other voxels leave as gray.
// The APB port holds target_label at byte address 0; pready is always high.
// A word is captured in an input register, coloured by one combinational
// pass and captured in a result register, from which it is offered on the
// pixel channel.
// Throughput is one word per clock while the receiver does not stall, set by
// the two-register pipeline.
// When the receiver stalls the result register holds, and the input register
// still fills; ready drops only when both registers are full and stalled.
// Reset clears both valid flags and sets target_label to 0.
`default_nettype none
module label_pseudocolor_ycgco_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lpy_pkg::ApbAddrW-1:0] paddr,
	input  wire logic [lpy_pkg::ApbDataW-1:0] pwdata,
	output logic      [lpy_pkg::ApbDataW-1:0] prdata,
	output logic                              pready,
	lpy_vox_if.sink                           voxel,
	lpy_pix_if.source                         pixel
);
	import lpy_pkg::*;

	chan_t target_label;
	logic  valid_s1, valid_s2, adv_s1, adv_s2;
	chan_t intensity_s1, voxel_label_s1;
	chan_t red_c, green_c, blue_c;
	chan_t red_s2, green_s2, blue_s2;

	lpy_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.target_label(target_label)
	);

	assign adv_s2      = !valid_s2 || pixel.ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign voxel.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= voxel.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && voxel.valid) begin
			intensity_s1   <= voxel.intensity;
			voxel_label_s1 <= voxel.voxel_label;
		end
		if (adv_s2 && valid_s1) begin
			red_s2   <= red_c;
			green_s2 <= green_c;
			blue_s2  <= blue_c;
		end
	end

	lpy_color u_color (
		.intensity   (intensity_s1),
		.voxel_label (voxel_label_s1),
		.target_label(target_label),
		.red         (red_c),
		.green       (green_c),
		.blue        (blue_c)
	);

	assign pixel.valid = valid_s2;
	assign pixel.red   = red_s2;
	assign pixel.green = green_s2;
	assign pixel.blue  = blue_s2;
endmodule
`default_nettype wire

@@ tb/tb_label_pseudocolor_ycgco_top.sv @@
`default_nettype none
module tb_label_pseudocolor_ycgco_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lpy_pkg::*;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pixel_t;

	localparam logic [ApbAddrW-1:0] TargetAddr = ApbAddrW'(4 * REG_TARGET_LABEL);
	localparam logic [ApbAddrW-1:0] SpareAddr  = ApbAddrW'(4 * (REG_TARGET_LABEL + 1));
	localparam int unsigned CycleLimit = 200_000;

	class colour_checker;
		chan_t       target;
		pixel_t      awaited[$];
		int unsigned faults;

		function new();
			target = '0;
			faults = 0;
		endfunction

		function int sat12(int v);
			if (v < 0) return 0;
			if (v > int'(Full)) return int'(Full);
			return v;
		endfunction

		function pixel_t shade(chan_t intensity, chan_t label);
			int     lvl, hr, hg, hb, cg, co, num;
			pixel_t px;
			lvl = int'(intensity);
			if (label != target) begin
				px.red   = intensity;
				px.green = intensity;
				px.blue  = intensity;
				return px;
			end
			hr = sat12(4 * lvl - 8190);
			hg = 4 * lvl;
			if (hg > int'(Full)) hg = int'(Full);
			if (16380 - 4 * lvl < hg) hg = 16380 - 4 * lvl;
			hg = sat12(hg);
			hb = sat12(8190 - 4 * lvl);
			num = 2 * hg - hr - hb + 8190;
			cg = num > 0 ? num / 4 : 0;
			num = hr - hb + int'(Full);
			co = num > 0 ? num / 2 : 0;
			px.red   = chan_t'(sat12(lvl - cg + co));
			px.green = chan_t'(sat12(lvl + cg - 2048));
			px.blue  = chan_t'(sat12(lvl - cg - co + int'(Full)));
			return px;
		endfunction

		function void note_voxel(chan_t intensity, chan_t label);
			awaited.push_back(shade(intensity, label));
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (awaited.size() == 0) begin
				$error("pixel word arrived with none awaited");
				faults++;
				return;
			end
			want = awaited.pop_front();
			if (got.red != want.red) begin
				$error("red: expected %0d, got %0d", want.red, got.red);
				faults++;
			end
			if (got.green != want.green) begin
				$error("green: expected %0d, got %0d", want.green, got.green);
				faults++;
			end
			if (got.blue != want.blue) begin
				$error("blue: expected %0d, got %0d", want.blue, got.blue);
				faults++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	lpy_vox_if voxel ();
	lpy_pix_if pixel ();

	colour_checker chk = new();

	int          src_idle_pct  = 0;
	int          sink_idle_pct = 0;
	int          hold_off_left = 0;
	int unsigned cycle_count   = 0;
	int          corner_lvl[11] = '{0, 1, 1023, 1024, 1536, 2047, 2048, 2049, 3071, 3072, 4095};

	label_pseudocolor_ycgco_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.voxel   (voxel),
		.pixel   (pixel)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("tb_label_pseudocolor_ycgco_top: errors");
			$finish;
		end
	end

	initial pixel.ready = 1'b0;

	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			pixel.ready = 1'b0;
			hold_off_left--;
		end else begin
			pixel.ready = ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pixel.valid && pixel.ready)
			chk.check_pixel({pixel.red, pixel.green, pixel.blue});
	end

	task automatic send_voxel(input chan_t intensity, input chan_t label);
		while ($urandom_range(99) < src_idle_pct) begin
			voxel.valid = 1'b0;
			@(negedge clk);
		end
		voxel.valid       = 1'b1;
		voxel.intensity   = intensity;
		voxel.voxel_label = label;
		@(posedge clk);
		while (!voxel.ready) @(posedge clk);
		chk.note_voxel(intensity, label);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		voxel.valid = 1'b0;
		while (chk.awaited.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Writes one register, then reads target_label back through the same port.
	task automatic program_reg(input logic [ApbAddrW-1:0] addr,
			input logic [ApbDataW-1:0] data);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == TargetAddr) chk.target = data[DataW-1:0];
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = TargetAddr;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[DataW-1:0] !== chk.target) begin
			$error("target_label: expected %0d, got %0d", chk.target, prdata[DataW-1:0]);
			chk.faults++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic run_random(input int count);
		chan_t lvl;
		chan_t lab;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(15) == 0)
				lvl = $urandom_range(1) ? Full : chan_t'(0);
			else
				lvl = chan_t'($urandom_range(4095));
			lab = $urandom_range(1) ? chk.target : chan_t'($urandom_range(4095));
			send_voxel(lvl, lab);
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		voxel.valid       = 1'b0;
		voxel.intensity   = '0;
		voxel.voxel_label = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset value of target_label is zero, so label zero is coloured here.
		foreach (corner_lvl[k])
			send_voxel(chan_t'(corner_lvl[k]), chan_t'(0));
		send_voxel(chan_t'(0), Full);
		send_voxel(Full, Full);
		wait_drained();

		// Upper bits of the write word are dropped by the 12-bit register.
		program_reg(TargetAddr, 32'hFFFF_FFFF);
		send_voxel(chan_t'(0), Full);
		send_voxel(Full, Full);
		send_voxel(chan_t'(2048), Full);
		send_voxel(chan_t'(3000), chan_t'(4094));
		send_voxel(chan_t'(3000), chan_t'(0));
		wait_drained();

		program_reg(SpareAddr, 32'h0000_0123);
		send_voxel(chan_t'(2500), chan_t'(12'h123));
		send_voxel(chan_t'(2500), Full);
		wait_drained();

		src_idle_pct  = 9;
		sink_idle_pct = 74;
		program_reg(TargetAddr, ApbDataW'($urandom_range(4095)));
		run_random(320);
		wait_drained();

		src_idle_pct  = 74;
		sink_idle_pct = 9;
		program_reg(TargetAddr, '0);
		run_random(320);
		wait_drained();

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		program_reg(TargetAddr, $urandom);
		hold_off_left = 60;
		run_random(12);
		wait_drained();
		run_random(298);
		wait_drained();

		repeat (8) @(posedge clk);
		if (chk.faults == 0 && chk.awaited.size() == 0)
			$display("tb_label_pseudocolor_ycgco_top: clean");
		else
			$display("tb_label_pseudocolor_ycgco_top: errors");
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
design/lpy_pkg.sv
design/lpy_if.sv
design/lpy_apb_regs.sv
design/lpy_color.sv
design/label_pseudocolor_ycgco_top.sv
tb/tb_label_pseudocolor_ycgco_top.sv
